@@ rtl/core/eazt_pkg.sv @@
// Shared types, widths and constants for the encoder angle zero tracker.
// Used by the tracker top level and its port checker; depends on nothing.
`default_nettype none

package eazt_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int FRAC_BITS  = 13;
  localparam int CNT_W      = 8;
  localparam int ANG_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam int SUM_W      = ANGLE_BITS + CNT_W + 1;
  localparam int SHR_W      = SUM_W - 1;
  localparam int DIV_STEPS  = SHR_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int DIFF_W     = ANGLE_BITS + 2;
  localparam int NDIV_W     = CNT_W + 1;

  localparam int CONST_W    = 35;
  localparam int PROD_W     = CONST_W + ANGLE_BITS;
  localparam int RAD_SHIFT  = 32 + ANGLE_BITS - FRAC_BITS;
  localparam logic [PROD_W-1:0] TWO_PI_Q32 = PROD_W'(35'd26986075409);
  localparam logic [PROD_W-1:0] ROUND_SEED = PROD_W'(1) << (RAD_SHIFT - 1 - ANGLE_BITS);

  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(1) << ANGLE_BITS;
  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(1) << (ANGLE_BITS - 1);

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = CNT_W'(16);

  localparam int S_DATA_W   = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int S_USER_W   = MODE_W + 1;
  localparam int FAULT_BIT  = MODE_W;

  localparam int OUT_RAW_LSB = 0;
  localparam int OUT_ABS_LSB = OUT_RAW_LSB + ANGLE_BITS;
  localparam int OUT_OFF_LSB = OUT_ABS_LSB + ANG_W;
  localparam int ZVALID_BIT  = OUT_OFF_LSB + ANG_W;
  localparam int ZPOINT_LSB  = ZVALID_BIT + 1;
  localparam int DONE_BIT    = ZPOINT_LSB + ANGLE_BITS;
  localparam int OUT_USED_W  = DONE_BIT + 1;
  localparam int M_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REF     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAULT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_ABS,
    ST_OFF,
    ST_DONE
  } state_t;

  function automatic logic signed [DIFF_W-1:0] wrapped_diff(
    input logic [ANGLE_BITS-1:0] cur,
    input logic [ANGLE_BITS-1:0] base
  );
    logic signed [DIFF_W-1:0] d;
    d = $signed({2'b00, cur}) - $signed({2'b00, base});
    if (d > HALF_TURN) begin
      d = d - FULL_TURN;
    end else if (d < -HALF_TURN) begin
      d = d + FULL_TURN;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/encoder_angle_zero_tracker.sv @@
// Encoder angle zero tracker: top level with sequencer and one shared adder.
// Depends on eazt_pkg.
//
// Usage:
//   Input items arrive on s_axis (tdata: raw_angle; tuser: mode, sensor_fault).
//   Each item gives exactly one result on m_axis (tdata: angles and zero point;
//   tuser: status). Registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
//   Sequencer path from the accepted item to m_axis_tvalid rising:
//     reference, fault, stray or rejected item: EVAL, DONE;
//     measure item: EVAL, ABS, then OFF once a zero point exists, DONE;
//     completing calibration sample: EVAL, DIV, ABS, OFF, DONE.
//   One shared adder does the shift-add multiply into radians and the
//   restoring divide for the calibration mean.
//   s_axis_tready is high only while the sequencer is idle; one item is in
//   work at a time. A finished result sits in the output register, and the
//   next item is taken while it waits; a later result holds in the sequencer
//   until the output register is free.
//   Reset clears all tracked state, drops any pending result and restores
//   sample_count to 16 and direction_negative to 0.
`default_nettype none

module encoder_angle_zero_tracker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // raw_angle
  input  wire  [eazt_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // mode, sensor_fault
  input  wire  [eazt_pkg::S_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // raw_out, absolute_angle, offset_angle, zero_valid, zero_point, calibration_done
  output logic [eazt_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // status
  output logic [eazt_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  wire                               cfg_we,
  input  wire  [eazt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [eazt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import eazt_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]        sample_count;
  logic                    direction_negative;

  logic [ANGLE_BITS-1:0]   last_raw;
  logic [ANG_W-1:0]        held_absolute;
  logic [ANG_W-1:0]        held_offset;
  logic [ANGLE_BITS-1:0]   zero_raw;
  logic                    zero_defined;
  logic [ANGLE_BITS-1:0]   cal_reference;
  logic signed [SUM_W-1:0] cal_sum;
  logic [CNT_W-1:0]        cal_taken;
  logic                    cal_active;

  logic [MODE_W-1:0]       mode_r;
  logic [ANGLE_BITS-1:0]   raw_r;
  logic                    fault_r;
  logic [STATUS_W-1:0]     status_r;
  logic                    done_r;

  logic [PROD_W-1:0]       acc;
  logic [SHR_W-1:0]        shreg;
  logic [STEP_W-1:0]       step;
  logic [NDIV_W-1:0]       div_n;
  logic                    div_neg;
  logic                    off_neg;

  logic [ANGLE_BITS-1:0]   out_raw;
  logic [ANG_W-1:0]        out_abs;
  logic [ANG_W-1:0]        out_off;
  logic                    out_zvalid;
  logic [ANGLE_BITS-1:0]   out_zpoint;
  logic                    out_done;
  logic [STATUS_W-1:0]     out_status;

  logic                    in_accept;
  logic                    out_free;
  logic                    last_mul;
  logic                    last_div;

  logic [CNT_W-1:0]        taken_inc;
  logic signed [DIFF_W-1:0] eval_diff;
  logic signed [SUM_W-1:0] sum_upd;
  logic [SUM_W-1:0]        sum_neg_val;
  logic [SHR_W-1:0]        sum_mag;
  logic                    go_abs;
  logic                    go_div;

  logic [CNT_W:0]          rem_sh;
  logic [PROD_W-1:0]       add_a;
  logic [PROD_W-1:0]       add_b;
  logic [PROD_W-1:0]       add_sum;
  logic                    qbit;
  logic [SHR_W-1:0]        quot;
  logic [ANGLE_BITS-1:0]   mean_w;
  logic [ANG_W-1:0]        rad_val;

  logic signed [DIFF_W-1:0] off_d;
  logic [DIFF_W-1:0]       off_d_neg;
  logic [ANGLE_BITS-1:0]   off_mag;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign last_mul  = (step == STEP_W'(ANGLE_BITS - 1));
  assign last_div  = (step == STEP_W'(DIV_STEPS - 1));

  // Decision for the captured item
  always_comb begin
    taken_inc   = cal_taken + CNT_W'(1);
    eval_diff   = wrapped_diff(raw_r, cal_reference);
    sum_upd     = cal_sum + SUM_W'(eval_diff);
    sum_neg_val = -sum_upd;
    sum_mag     = sum_upd[SUM_W-1] ? sum_neg_val[SHR_W-1:0] : sum_upd[SHR_W-1:0];
    go_abs      = (mode_r == MODE_MEASURE) && !fault_r;
    go_div      = (mode_r == MODE_SAMPLE) && cal_active && !fault_r &&
                  (sample_count != '0) &&
                  ((taken_inc >= sample_count) || (taken_inc == '0));
  end

  // Shared adder: shift-add multiply or restoring subtract
  always_comb begin
    rem_sh = {acc[CNT_W-1:0], shreg[SHR_W-1]};
    case (state)
      ST_DIV: begin
        add_a = PROD_W'(rem_sh);
        add_b = -PROD_W'(div_n);
      end
      default: begin
        add_a = {acc[PROD_W-2:0], 1'b0};
        add_b = shreg[SHR_W-1] ? TWO_PI_Q32 : '0;
      end
    endcase
    add_sum = add_a + add_b;
    qbit    = !add_sum[PROD_W-1];
    quot    = {shreg[SHR_W-2:0], qbit};
    mean_w  = div_neg ? -quot[ANGLE_BITS-1:0] : quot[ANGLE_BITS-1:0];
    rad_val = add_sum[RAD_SHIFT +: ANG_W];
  end

  always_comb begin
    off_d     = wrapped_diff(raw_r, zero_raw);
    off_d_neg = -off_d;
    off_mag   = off_d[DIFF_W-1] ? off_d_neg[ANGLE_BITS-1:0] : off_d[ANGLE_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (go_abs) state_next = ST_ABS;
        else if (go_div) state_next = ST_DIV;
        else state_next = ST_DONE;
      end
      ST_DIV: begin
        if (last_div) state_next = ST_ABS;
      end
      ST_ABS: begin
        if (last_mul) state_next = zero_defined ? ST_OFF : ST_DONE;
      end
      ST_OFF: begin
        if (last_mul) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= SAMPLE_COUNT_RESET;
      direction_negative <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count       <= cfg_data;
        CFG_DIRECTION:    direction_negative <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Tracked state and sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= '0;
      held_absolute <= '0;
      held_offset   <= '0;
      zero_raw      <= '0;
      zero_defined  <= 1'b0;
      cal_reference <= '0;
      cal_sum       <= '0;
      cal_taken     <= '0;
      cal_active    <= 1'b0;
    end else begin
      case (state)
        ST_EVAL: begin
          case (mode_r)
            MODE_MEASURE: begin
              last_raw <= raw_r;
            end
            MODE_REF: begin
              if (sample_count == '0) begin
                cal_active <= 1'b0;
              end else if (!fault_r) begin
                cal_reference <= raw_r;
                cal_sum       <= '0;
                cal_taken     <= '0;
                cal_active    <= 1'b1;
              end else begin
                cal_active <= 1'b0;
              end
            end
            MODE_SAMPLE: begin
              if (cal_active) begin
                if (fault_r) begin
                  cal_active <= 1'b0;
                end else begin
                  cal_sum   <= sum_upd;
                  cal_taken <= taken_inc;
                  if ((sample_count == '0) || go_div) cal_active <= 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (last_div) begin
            zero_raw     <= cal_reference + mean_w;
            zero_defined <= 1'b1;
            last_raw     <= raw_r;
          end
        end
        ST_ABS: begin
          if (last_mul) held_absolute <= rad_val;
        end
        ST_OFF: begin
          if (last_mul) held_offset <= off_neg ? -rad_val : rad_val;
        end
        default: ;
      endcase
    end
  end

  // Item capture, status and the shared unit's working registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r   <= s_axis_tuser[MODE_W-1:0];
      raw_r    <= s_axis_tdata[ANGLE_BITS-1:0];
      fault_r  <= s_axis_tuser[FAULT_BIT];
      status_r <= STATUS_OK;
      done_r   <= 1'b0;
    end
    case (state)
      ST_EVAL: begin
        step <= '0;
        case (mode_r)
          MODE_MEASURE: begin
            if (fault_r) status_r <= STATUS_FAULT;
            shreg <= {raw_r, (SHR_W - ANGLE_BITS)'(0)};
            acc   <= ROUND_SEED;
          end
          MODE_REF: begin
            if (sample_count == '0) status_r <= STATUS_REJECT;
            else if (fault_r) status_r <= STATUS_FAULT;
          end
          MODE_SAMPLE: begin
            if (!cal_active) status_r <= STATUS_REJECT;
            else if (fault_r) status_r <= STATUS_FAULT;
            else if (sample_count == '0) status_r <= STATUS_REJECT;
            shreg   <= sum_mag;
            acc     <= '0;
            div_n   <= {taken_inc == '0, taken_inc};
            div_neg <= sum_upd[SUM_W-1];
            if (go_div) done_r <= 1'b1;
          end
          default: status_r <= STATUS_REJECT;
        endcase
      end
      ST_DIV: begin
        if (last_div) begin
          step  <= '0;
          shreg <= {raw_r, (SHR_W - ANGLE_BITS)'(0)};
          acc   <= ROUND_SEED;
        end else begin
          step  <= step + STEP_W'(1);
          shreg <= quot;
          acc   <= qbit ? add_sum : PROD_W'(rem_sh);
        end
      end
      ST_ABS: begin
        if (last_mul) begin
          step    <= '0;
          shreg   <= {off_mag, (SHR_W - ANGLE_BITS)'(0)};
          acc     <= ROUND_SEED;
          off_neg <= off_d[DIFF_W-1] ^ direction_negative;
        end else begin
          step  <= step + STEP_W'(1);
          shreg <= {shreg[SHR_W-2:0], 1'b0};
          acc   <= add_sum;
        end
      end
      ST_OFF: begin
        step  <= step + STEP_W'(1);
        shreg <= {shreg[SHR_W-2:0], 1'b0};
        acc   <= add_sum;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_status <= status_r;
      out_raw    <= last_raw;
      out_abs    <= held_absolute;
      out_off    <= held_offset;
      out_zvalid <= zero_defined;
      out_zpoint <= zero_raw;
      out_done   <= done_r;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {(M_DATA_W - OUT_USED_W)'(0), out_done, out_zpoint, out_zvalid,
                         out_off, out_abs, out_raw};

endmodule

`default_nettype wire

@@ rtl/core/eazt_checker.sv @@
// Port-level checker for the encoder angle zero tracker, bound to the top level.
// Depends on eazt_pkg and encoder_angle_zero_tracker.
`default_nettype none

module eazt_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [eazt_pkg::S_DATA_W-1:0]      s_axis_tdata,
  input wire [eazt_pkg::S_USER_W-1:0]      s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [eazt_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input wire [eazt_pkg::STATUS_W-1:0]      m_axis_tuser,
  input wire                               cfg_we,
  input wire [eazt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire [eazt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import eazt_pkg::*;

  a_reset_drops_result: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_done_sets_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[DONE_BIT] |->
      m_axis_tuser == STATUS_OK && m_axis_tdata[ZVALID_BIT])
    else $error("completed calibration without valid zero point");

endmodule

bind encoder_angle_zero_tracker eazt_checker u_eazt_checker (.*);

`default_nettype wire
